// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files of the usage set change detector.
// Stand-alone header; each macro checks on the rising clock edge outside of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/uscd_pkg.sv =====
// Package for the usage set change detector: sizes, constants and the record
// types passed between the modules. It depends on nothing else.
package uscd_pkg;

    localparam int SLOT_COUNT   = 3;   // entries of the held set, 1 to 8
    localparam int OUT_SLOTS    = 3;   // usage fields in a request and in a result
    localparam int CODE_W       = 16;
    localparam int LEN_W        = 7;
    localparam int OUT_CNT_W    = 2;
    localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
    localparam int REPORT_BYTES = 8;   // shortest report that is accepted

    localparam int IN_DATA_W  = OUT_SLOTS * CODE_W + LEN_W;
    localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 2 * (OUT_CNT_W + OUT_SLOTS * CODE_W);
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [SLOT_COUNT-1:0][CODE_W-1:0] t_held;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [LEN_W-1:0]                 length;
        logic [OUT_SLOTS-1:0][CODE_W-1:0] usage;
    } t_report;

    typedef struct packed {
        logic                             error_flag;
        logic [OUT_CNT_W-1:0]             press_total;
        logic [OUT_SLOTS-1:0][CODE_W-1:0] pressed;
        logic [OUT_CNT_W-1:0]             release_total;
        logic [OUT_SLOTS-1:0][CODE_W-1:0] released;
    } t_result;

endpackage

// ===== design/uscd_diff.sv =====
// Combinational set compare for one report against the held set.
// Depends on uscd_pkg for sizes and the report and result records.
module uscd_diff (
    input  uscd_pkg::t_report i_report,
    input  uscd_pkg::t_held   i_held,
    output uscd_pkg::t_result o_result,
    output uscd_pkg::t_held   o_next_held
);

    uscd_pkg::t_code [uscd_pkg::SLOT_COUNT-1:0] w_code;
    logic [uscd_pkg::SLOT_COUNT-1:0]            w_keep;
    logic [uscd_pkg::SLOT_COUNT-1:0]            w_new;
    logic [uscd_pkg::SLOT_COUNT-1:0]            w_gone;
    uscd_pkg::t_cnt [uscd_pkg::SLOT_COUNT-1:0]  w_keep_rank;
    uscd_pkg::t_cnt [uscd_pkg::SLOT_COUNT-1:0]  w_new_rank;
    uscd_pkg::t_cnt [uscd_pkg::SLOT_COUNT-1:0]  w_gone_rank;
    uscd_pkg::t_cnt                             w_keep_cnt;
    uscd_pkg::t_cnt                             w_new_cnt;
    uscd_pkg::t_cnt                             w_gone_cnt;
    uscd_pkg::t_held                            w_fresh;
    uscd_pkg::t_held                            w_pressed;
    uscd_pkg::t_held                            w_released;
    logic                                       w_short;

    assign w_short = i_report.length < uscd_pkg::LEN_W'(uscd_pkg::REPORT_BYTES);

    // Slots beyond the report's usage fields read as empty.
    always_comb begin
        for (int i = 0; i < uscd_pkg::SLOT_COUNT; i++) begin
            w_code[i] = '0;
            if (i < uscd_pkg::OUT_SLOTS) begin
                w_code[i] = i_report.usage[i];
            end
        end
    end

    // A code is kept when it is nonzero and no earlier slot carries it. A kept
    // code is newly pressed when the held set lacks it. A held code is released
    // when no slot of the report carries it.
    always_comb begin
        for (int i = 0; i < uscd_pkg::SLOT_COUNT; i++) begin
            w_keep[i] = (w_code[i] != '0);
            for (int j = 0; j < i; j++) begin
                if (w_code[j] == w_code[i]) begin
                    w_keep[i] = 1'b0;
                end
            end
            w_new[i] = w_keep[i];
            for (int j = 0; j < uscd_pkg::SLOT_COUNT; j++) begin
                if (i_held[j] == w_code[i]) begin
                    w_new[i] = 1'b0;
                end
            end
            w_gone[i] = (i_held[i] != '0);
            for (int j = 0; j < uscd_pkg::SLOT_COUNT; j++) begin
                if (w_code[j] == i_held[i]) begin
                    w_gone[i] = 1'b0;
                end
            end
        end
    end

    // Running ranks give each surviving entry its packed position.
    always_comb begin
        w_keep_cnt = '0;
        w_new_cnt  = '0;
        w_gone_cnt = '0;
        for (int i = 0; i < uscd_pkg::SLOT_COUNT; i++) begin
            w_keep_rank[i] = w_keep_cnt;
            w_new_rank[i]  = w_new_cnt;
            w_gone_rank[i] = w_gone_cnt;
            w_keep_cnt = w_keep_cnt + uscd_pkg::CNT_W'(w_keep[i]);
            w_new_cnt  = w_new_cnt + uscd_pkg::CNT_W'(w_new[i]);
            w_gone_cnt = w_gone_cnt + uscd_pkg::CNT_W'(w_gone[i]);
        end
    end

    always_comb begin
        w_fresh    = '0;
        w_pressed  = '0;
        w_released = '0;
        for (int k = 0; k < uscd_pkg::SLOT_COUNT; k++) begin
            for (int i = 0; i < uscd_pkg::SLOT_COUNT; i++) begin
                if (w_keep[i] && (w_keep_rank[i] == uscd_pkg::CNT_W'(k))) begin
                    w_fresh[k] = w_code[i];
                end
                if (w_new[i] && (w_new_rank[i] == uscd_pkg::CNT_W'(k))) begin
                    w_pressed[k] = w_code[i];
                end
                if (w_gone[i] && (w_gone_rank[i] == uscd_pkg::CNT_W'(k))) begin
                    w_released[k] = i_held[i];
                end
            end
        end
    end

    always_comb begin
        o_result    = '0;
        o_next_held = i_held;
        if (w_short) begin
            o_result.error_flag = 1'b1;
        end else begin
            o_next_held = w_fresh;
            if (int'(w_new_cnt) > uscd_pkg::OUT_SLOTS) begin
                o_result.press_total = uscd_pkg::OUT_CNT_W'(uscd_pkg::OUT_SLOTS);
            end else begin
                o_result.press_total = uscd_pkg::OUT_CNT_W'(w_new_cnt);
            end
            if (int'(w_gone_cnt) > uscd_pkg::OUT_SLOTS) begin
                o_result.release_total = uscd_pkg::OUT_CNT_W'(uscd_pkg::OUT_SLOTS);
            end else begin
                o_result.release_total = uscd_pkg::OUT_CNT_W'(w_gone_cnt);
            end
            for (int k = 0; k < uscd_pkg::OUT_SLOTS; k++) begin
                if (k < uscd_pkg::SLOT_COUNT) begin
                    o_result.pressed[k]  = w_pressed[k];
                    o_result.released[k] = w_released[k];
                end
            end
        end
    end

endmodule

// ===== design/usage_set_change_detector.sv =====
// Top level of the usage set change detector: input register, set compare and
// result register. Depends on uscd_pkg, uscd_diff and assert_macros.svh.
//
// Each request is one keyboard-style report reduced to its three 16-bit usage
// codes and its byte length. The block drops empty (zero) codes and repeats,
// compares the remaining set with the set held from the previous good report,
// and returns one result per request: the newly pressed codes in report order,
// the released codes in held-slot order, a count for each list, and an error
// flag. A report shorter than eight bytes returns the error flag with zero
// counts and codes and leaves the held set as it was. Unused list entries are
// zero. Reset empties the held set. The block takes one request per clock
// cycle for as long as results are taken; each request passes through the
// input register and then the result register. The held set is updated as
// a request passes from the input register into the result register, so a
// request accepted in the very next cycle already compares against the
// updated set. A stalled result holds the result register, and the input
// register can still take one more request before the slave side stalls in
// turn.
`include "assert_macros.svh"

module usage_set_change_detector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: usage_first[15:0], usage_second[31:16],
    // usage_third[47:32], report_length[54:48], zero fill [55].
    input  logic [uscd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0 up: press_total[1:0], pressed_first[17:2],
    // pressed_second[33:18], pressed_third[49:34], release_total[51:50],
    // released_first[67:52], released_second[83:68], released_third[99:84],
    // zero fill [103:100].
    output logic [uscd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0 up: error_flag[0].
    output logic                                 m_axis_tuser
);

    logic                r_in_valid;
    uscd_pkg::t_report   r_in;
    uscd_pkg::t_report   w_in;
    logic                r_out_valid;
    uscd_pkg::t_result   r_out;
    uscd_pkg::t_result   w_result;
    uscd_pkg::t_held     r_held;
    uscd_pkg::t_held     w_next_held;
    logic                w_accept;
    logic                w_advance;

    // Unpack the request: usage codes low, length above them.
    always_comb begin
        for (int i = 0; i < uscd_pkg::OUT_SLOTS; i++) begin
            w_in.usage[i] = s_axis_tdata[i*uscd_pkg::CODE_W +: uscd_pkg::CODE_W];
        end
        w_in.length = s_axis_tdata[uscd_pkg::OUT_SLOTS*uscd_pkg::CODE_W +: uscd_pkg::LEN_W];
    end

    // The input register moves on whenever the result register is empty or
    // being emptied in this cycle.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    uscd_diff u_diff (
        .i_report    (r_in),
        .i_held      (r_held),
        .o_result    (w_result),
        .o_next_held (w_next_held)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_held      <= w_next_held;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= w_in;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    // Pack the result; the error flag goes out on the user sideband.
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[uscd_pkg::OUT_DATA_W-1:0] = {r_out.released, r_out.release_total,
                                                 r_out.pressed, r_out.press_total};
    end
    assign m_axis_tuser  = r_out.error_flag;
    assign m_axis_tvalid = r_out_valid;

    // An error result never reports pressed or released codes.
    `ASSERT_IMPL(a_error_zero_counts, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser,
        (r_out.press_total == '0) && (r_out.release_total == '0),
        "error result carries nonzero counts")
    // A short report passing into the result register leaves the held set alone.
    `ASSERT_NEXT(a_short_keeps_held, i_clk, i_rst_n,
        w_advance && (r_in.length < uscd_pkg::LEN_W'(uscd_pkg::REPORT_BYTES)),
        $stable(r_held),
        "short report changed the held set")
    // An empty result register never stalls the slave side.
    `ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n,
        !r_out_valid,
        s_axis_tready,
        "slave side stalled with an empty result register")
    // The held set only changes when a request passes the compare stage.
    `ASSERT_NEXT(a_held_moves_on_advance, i_clk, i_rst_n,
        !w_advance,
        $stable(r_held),
        "held set changed without a request passing")

endmodule

// ===== tb/sv/usage_set_change_detector_tb.sv =====
// Self-checking testbench for the usage set change detector: drives reports on the
// request stream, predicts each pressed/released result and compares it field by field.
// Depends on uscd_pkg and the design files; uses no file, argument or foreign code.
module usage_set_change_detector_tb;

    localparam int CODE_W       = uscd_pkg::CODE_W;
    localparam int LEN_W        = uscd_pkg::LEN_W;
    localparam int OUT_SLOTS    = uscd_pkg::OUT_SLOTS;
    localparam int OUT_CNT_W    = uscd_pkg::OUT_CNT_W;
    localparam int REPORT_BYTES = uscd_pkg::REPORT_BYTES;
    localparam int IN_TDATA_W   = uscd_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W  = uscd_pkg::OUT_TDATA_W;

    // One report as the testbench builds it; usage[0] is the first slot.
    typedef struct packed {
        logic [LEN_W-1:0]                 length;
        logic [OUT_SLOTS-1:0][CODE_W-1:0] usage;
    } t_tb_report;

    // One expected pressed/released result.
    typedef struct packed {
        logic                             error_flag;
        logic [OUT_CNT_W-1:0]             press_total;
        logic [OUT_SLOTS-1:0][CODE_W-1:0] pressed;
        logic [OUT_CNT_W-1:0]             release_total;
        logic [OUT_SLOTS-1:0][CODE_W-1:0] released;
    } t_key_change;

    localparam int PRESSED_LSB  = OUT_CNT_W;
    localparam int RELEASED_CNT = OUT_CNT_W + OUT_SLOTS * CODE_W;
    localparam int RELEASED_LSB = RELEASED_CNT + OUT_CNT_W;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // Fields from bit 0 up: usage_first, usage_second, usage_third, report_length, zero fill.
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // Fields from bit 0 up: press_total, pressed_first..third, release_total,
    // released_first..third, zero fill.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // Fields from bit 0 up: error_flag.
    logic                   m_axis_tuser;

    // Held set of the predictor and the results still owed by the block.
    logic [OUT_SLOTS-1:0][CODE_W-1:0] held_keys;
    t_key_change                      pending_changes[$];

    int mismatch_count  = 0;
    int reports_sent    = 0;
    int short_reports   = 0;
    int changes_checked = 0;
    int send_calm       = 0;
    int take_calm       = 0;

    usage_set_change_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Wait in cycles before the next request or result; now and then a calm
    // stretch of back-to-back traffic with no waiting at all.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic holds_code(input logic [OUT_SLOTS-1:0][CODE_W-1:0] set,
                                        input logic [CODE_W-1:0] code);
        for (int i = 0; i < OUT_SLOTS; i++) begin
            if (set[i] == code) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Works out the pressed and released lists for one report and moves the
    // held set forward. A short report changes nothing and flags an error.
    function automatic t_key_change predict_key_change(input t_tb_report r);
        t_key_change                      c;
        logic [OUT_SLOTS-1:0][CODE_W-1:0] fresh;
        int                               filled;
        int                               pc;
        int                               rc;
        c      = '0;
        fresh  = '0;
        filled = 0;
        pc     = 0;
        rc     = 0;
        if (r.length < REPORT_BYTES) begin
            c.error_flag = 1'b1;
            return c;
        end
        // Empty slots and repeats drop out; the rest pack to the front.
        for (int i = 0; i < OUT_SLOTS; i++) begin
            if (r.usage[i] != '0 && !holds_code(fresh, r.usage[i])) begin
                fresh[filled] = r.usage[i];
                filled++;
            end
        end
        for (int i = 0; i < filled; i++) begin
            if (!holds_code(held_keys, fresh[i])) begin
                c.pressed[pc] = fresh[i];
                pc++;
            end
        end
        for (int i = 0; i < OUT_SLOTS; i++) begin
            if (held_keys[i] != '0 && !holds_code(fresh, held_keys[i])) begin
                c.released[rc] = held_keys[i];
                rc++;
            end
        end
        c.press_total   = pc[OUT_CNT_W-1:0];
        c.release_total = rc[OUT_CNT_W-1:0];
        held_keys       = fresh;
        return c;
    endfunction

    // Presents one report after a random wait and returns at the edge that
    // accepts it, with tvalid still high.
    task automatic send_report(input logic [CODE_W-1:0] u0, input logic [CODE_W-1:0] u1,
                               input logic [CODE_W-1:0] u2, input logic [LEN_W-1:0] len);
        t_tb_report r;
        int         gap;
        r.usage[0] = u0;
        r.usage[1] = u1;
        r.usage[2] = u2;
        r.length   = len;
        gap        = draw_wait(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.length, r.usage};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_changes.push_back(predict_key_change(r));
        reports_sent++;
        if (len < REPORT_BYTES) begin
            short_reports++;
        end
    endtask

    // Mostly lengths of a good report, some short ones and some above 64.
    function automatic logic [LEN_W-1:0] draw_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            return LEN_W'($urandom_range(0, REPORT_BYTES - 1));
        end
        if (pick == 2) begin
            return LEN_W'($urandom_range(65, 127));
        end
        return LEN_W'($urandom_range(REPORT_BYTES, 64));
    endfunction

    task automatic check_field(input string name, input logic [CODE_W-1:0] expd,
                               input logic [CODE_W-1:0] got);
        if (expd !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expd, got);
            mismatch_count++;
        end
    endtask

    // Result side: random stalls per result, then the result is taken.
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_key_change e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_changes.size() == 0) begin
                $error("result arrived with no request waiting for it");
                mismatch_count++;
            end else begin
                e = pending_changes.pop_front();
                changes_checked++;
                check_field("error_flag", CODE_W'(e.error_flag), CODE_W'(m_axis_tuser));
                check_field("press_total", CODE_W'(e.press_total),
                            CODE_W'(m_axis_tdata[OUT_CNT_W-1:0]));
                check_field("pressed_first", e.pressed[0],
                            m_axis_tdata[PRESSED_LSB +: CODE_W]);
                check_field("pressed_second", e.pressed[1],
                            m_axis_tdata[PRESSED_LSB + CODE_W +: CODE_W]);
                check_field("pressed_third", e.pressed[2],
                            m_axis_tdata[PRESSED_LSB + 2 * CODE_W +: CODE_W]);
                check_field("release_total", CODE_W'(e.release_total),
                            CODE_W'(m_axis_tdata[RELEASED_CNT +: OUT_CNT_W]));
                check_field("released_first", e.released[0],
                            m_axis_tdata[RELEASED_LSB +: CODE_W]);
                check_field("released_second", e.released[1],
                            m_axis_tdata[RELEASED_LSB + CODE_W +: CODE_W]);
                check_field("released_third", e.released[2],
                            m_axis_tdata[RELEASED_LSB + 2 * CODE_W +: CODE_W]);
            end
        end
    end

    // Short reports right after reset and between good ones leave the held set alone.
    task automatic test_short_reports();
        send_report(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd0);
        send_report(16'h0004, 16'h0005, 16'h0006, 7'd7);
        send_report(16'h0004, 16'h0005, 16'h0006, 7'd8);
        send_report(16'h0000, 16'h0000, 16'h0000, 7'd7);
        send_report(16'h0004, 16'h0005, 16'h0006, 7'd8);
    endtask

    // Length limits and the extreme code values.
    task automatic test_length_extremes();
        send_report(16'hFFFF, 16'h0001, 16'h8000, 7'd64);
        send_report(16'h8000, 16'hFFFF, 16'h7FFF, 7'd127);
        send_report(16'h0001, 16'hFFFE, 16'h0000, 7'd8);
    endtask

    // Empty slots and repeated codes, including a fully empty report.
    task automatic test_empty_and_repeats();
        send_report(16'h0000, 16'h0000, 16'h0000, 7'd8);
        send_report(16'h0007, 16'h0007, 16'h0007, 7'd8);
        send_report(16'h0000, 16'h0009, 16'h0009, 7'd10);
        send_report(16'h0009, 16'h0000, 16'h0007, 7'd8);
        send_report(16'h000A, 16'h000B, 16'h000A, 7'd8);
    endtask

    // Full press, reordering with no change, full turnover and partial release.
    task automatic test_press_release();
        send_report(16'h0001, 16'h0002, 16'h0003, 7'd8);
        send_report(16'h0003, 16'h0002, 16'h0001, 7'd8);
        send_report(16'h0004, 16'h0005, 16'h0006, 7'd8);
        send_report(16'h0005, 16'h0000, 16'h0000, 7'd8);
        send_report(16'h5555, 16'hAAAA, 16'h0005, 7'd8);
        send_report(16'h0000, 16'h0000, 16'h0000, 7'd8);
    endtask

    // Typing-like traffic: each report evolves from the previous one using a
    // small pool of codes, so presses, holds, releases and repeats are common.
    task automatic test_random_typing(input int count);
        logic [CODE_W-1:0] pool [6];
        logic [CODE_W-1:0] slot [OUT_SLOTS];
        int                pick;
        for (int i = 0; i < OUT_SLOTS; i++) begin
            slot[i] = '0;
        end
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                foreach (pool[i]) begin
                    pool[i] = CODE_W'($urandom_range(1, 65535));
                end
            end
            for (int i = 0; i < OUT_SLOTS; i++) begin
                pick = $urandom_range(0, 19);
                if (pick < 3) begin
                    slot[i] = '0;
                end else if (pick < 8) begin
                    slot[i] = pool[$urandom_range(0, 5)];
                end else if (pick < 10) begin
                    slot[i] = CODE_W'($urandom_range(0, 65535));
                end
            end
            send_report(slot[0], slot[1], slot[2], draw_length());
        end
    endtask

    // Unrelated random reports over the whole range of every field.
    task automatic test_random_noise(input int count);
        for (int n = 0; n < count; n++) begin
            send_report(CODE_W'($urandom_range(0, 65535)), CODE_W'($urandom_range(0, 65535)),
                        CODE_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(0, 127)));
        end
    endtask

    initial begin
        held_keys = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_reports();
        test_length_extremes();
        test_empty_and_repeats();
        test_press_release();
        test_random_typing(540);
        test_random_noise(150);
        test_random_typing(50);

        s_axis_tvalid <= 1'b0;
        while (pending_changes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("Sent %0d reports (%0d short) and checked %0d pressed/released results.",
                 reports_sent, short_reports, changes_checked);
        $display("Covered short reports, length limits, repeats, empty slots and random typing.");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5000000;
        $display("Run stopped by timeout with %0d results outstanding.",
                 pending_changes.size());
        $display("status: fail");
        $finish;
    end

endmodule
